/* design/apufs_pkg.sv */
// Package with the command codes, count points and item layouts of the frame sequencer.
package apufs_pkg;

    // Master ticks per half-cycle advance of the frame counter.
    localparam int TICK_DIVIDE = 3;
    localparam int PHASE_W = (TICK_DIVIDE > 1) ? $clog2(TICK_DIVIDE) : 1;

    localparam int CNT_W = 16;
    localparam int DLY_W = 8;

    // Count points, in half-cycles.
    localparam logic [CNT_W-1:0] CNT_Q1    = CNT_W'(3728 * 2 + 1);
    localparam logic [CNT_W-1:0] CNT_Q2    = CNT_W'(7456 * 2 + 1);
    localparam logic [CNT_W-1:0] CNT_Q3    = CNT_W'(11185 * 2 + 1);
    localparam logic [CNT_W-1:0] CNT_IRQ_A = CNT_W'(14914 * 2);
    localparam logic [CNT_W-1:0] CNT_IRQ_B = CNT_W'(14914 * 2 + 1);
    localparam logic [CNT_W-1:0] CNT_WRAP4 = CNT_W'(14915 * 2);
    localparam logic [CNT_W-1:0] CNT_Q5    = CNT_W'(18640 * 2 + 1);
    localparam logic [CNT_W-1:0] CNT_WRAP5 = CNT_W'(18641 * 2);

    // Delay value that starts a pending action; bit 7 set means idle.
    localparam logic [DLY_W-1:0] DLY_START = DLY_W'(1);
    localparam logic [DLY_W-1:0] DLY_IDLE  = DLY_W'(8'hFF);

    localparam int FRAME_MODE_BIT = 7;
    localparam int FRAME_INH_BIT  = 6;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    // s_tdata: write_data [7:0], channel_active [12:8], dmc_irq_flag [13], zero [15:14]
    localparam int S_DATA_W = 16;
    // m_tdata: quarter_pulse [0], half_pulse [1], frame_irq [2], read_data [10:3],
    // zero [15:11]
    localparam int M_DATA_W = 16;

endpackage

/* design/apu_frame_sequencer_top.sv */
// Top level of the audio frame sequencer: tick, frame-register write and status read.
// An accepted item's result appears in the output register in the next cycle.
// Throughput: one item per cycle; s_tready is low only while a result is stalled.
// Every item is fully handled in the accept cycle by the counter and compare logic.
// Reset (aresetn low, synchronous): counter, phase, mode, flags cleared, delays idle,
// output register empty.
module apu_frame_sequencer_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // write_data [7:0], channel_active [12:8], dmc_irq_flag [13], zero [15:14]
    input  logic [apufs_pkg::S_DATA_W-1:0] s_tdata,
    // command [1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // quarter_pulse [0], half_pulse [1], frame_irq [2], read_data [10:3], zero [15:11]
    output logic [apufs_pkg::M_DATA_W-1:0] m_tdata
);
    import apufs_pkg::*;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               even_reg, even_next;
    logic               five_reg, five_next;
    logic               inh_reg, inh_next;
    logic               irq_reg, irq_next;
    logic [DLY_W-1:0]   icd_reg, icd_next;
    logic [DLY_W-1:0]   crd_reg, crd_next;
    logic               pq_reg, pq_next;
    logic               ph_reg, ph_next;
    logic               mvalid_reg;
    logic [M_DATA_W-1:0] mdata_reg, mdata_next;

    logic       accept;
    logic [7:0] wr_data;
    logic [4:0] chan_act;
    logic       dmc_irq;
    cmd_t       cmd;

    assign s_tready = !mvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign wr_data  = s_tdata[7:0];
    assign chan_act = s_tdata[12:8];
    assign dmc_irq  = s_tdata[13];
    assign cmd      = cmd_t'(s_tuser);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    always_comb begin
        logic             q, h;
        logic [7:0]       rd;
        logic [CNT_W-1:0] cnt;
        logic [DLY_W-1:0] icd_dec, crd_dec;

        count_next = count_reg;
        phase_next = phase_reg;
        even_next  = even_reg;
        five_next  = five_reg;
        inh_next   = inh_reg;
        irq_next   = irq_reg;
        icd_next   = icd_reg;
        crd_next   = crd_reg;
        pq_next    = pq_reg;
        ph_next    = ph_reg;
        q          = 1'b0;
        h          = 1'b0;
        rd         = 8'd0;
        cnt        = count_reg;
        icd_dec    = icd_reg - DLY_W'(1);
        crd_dec    = crd_reg - DLY_W'(1);

        case (cmd)
            CMD_TICK: begin
                if (phase_reg == PHASE_W'(0)) begin
                    even_next = !even_reg;
                    if (!even_reg) begin
                        // advance the delays on even half-cycles only
                        if (!icd_reg[7]) begin
                            icd_next = icd_dec;
                            if (icd_dec[7]) begin
                                irq_next = 1'b0;
                            end
                        end
                        if (!crd_reg[7]) begin
                            crd_next = crd_dec;
                            if (crd_dec[7]) begin
                                cnt = '0;
                            end
                        end
                    end
                    cnt = cnt + CNT_W'(1);
                    count_next = cnt;
                    case (cnt)
                        CNT_Q1: q = 1'b1;
                        CNT_Q2: begin
                            q = 1'b1;
                            h = 1'b1;
                        end
                        CNT_Q3: q = 1'b1;
                        CNT_IRQ_A: begin
                            if (!five_reg && !inh_reg) begin
                                irq_next = 1'b1;
                            end
                        end
                        CNT_IRQ_B: begin
                            if (!five_reg) begin
                                q = 1'b1;
                                h = 1'b1;
                                if (!inh_reg) begin
                                    irq_next = 1'b1;
                                end
                            end
                        end
                        CNT_WRAP4: begin
                            if (!five_reg) begin
                                count_next = '0;
                                if (!inh_reg) begin
                                    irq_next = 1'b1;
                                end
                            end
                        end
                        CNT_Q5: begin
                            q = 1'b1;
                            h = 1'b1;
                        end
                        CNT_WRAP5: count_next = '0;
                        default: ;
                    endcase
                    q = q || pq_reg;
                    h = h || ph_reg;
                end
                // drop pending pulses on every tick, active or not
                pq_next = 1'b0;
                ph_next = 1'b0;
                if (phase_reg == PHASE_W'(TICK_DIVIDE - 1)) begin
                    phase_next = '0;
                end else begin
                    phase_next = phase_reg + PHASE_W'(1);
                end
            end
            CMD_WRITE: begin
                five_next = wr_data[FRAME_MODE_BIT];
                inh_next  = wr_data[FRAME_INH_BIT];
                if (wr_data[FRAME_MODE_BIT]) begin
                    pq_next = 1'b1;
                    ph_next = 1'b1;
                end
                if (wr_data[FRAME_INH_BIT]) begin
                    irq_next = 1'b0;
                end
                crd_next = DLY_START;
            end
            CMD_READ: begin
                rd       = {irq_reg, dmc_irq, 1'b0, chan_act};
                icd_next = DLY_START;
            end
            default: ;
        endcase

        mdata_next = {5'd0, rd, irq_next, h, q};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            phase_reg  <= '0;
            even_reg   <= 1'b0;
            five_reg   <= 1'b0;
            inh_reg    <= 1'b0;
            irq_reg    <= 1'b0;
            icd_reg    <= DLY_IDLE;
            crd_reg    <= DLY_IDLE;
            pq_reg     <= 1'b0;
            ph_reg     <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
                phase_reg <= phase_next;
                even_reg  <= even_next;
                five_reg  <= five_next;
                inh_reg   <= inh_next;
                irq_reg   <= irq_next;
                icd_reg   <= icd_next;
                crd_reg   <= crd_next;
                pq_reg    <= pq_next;
                ph_reg    <= ph_next;
            end
            if (accept) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mdata_reg <= mdata_next;
        end
    end

endmodule

/* design/apufs_checker.sv */
// Port-level checker for the frame sequencer, bound to the top level.
module apufs_port_props (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [apufs_pkg::S_DATA_W-1:0] s_tdata,
    input logic [1:0]                     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [apufs_pkg::M_DATA_W-1:0] m_tdata
);
    import apufs_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a half-frame pulse always comes with a quarter-frame pulse
    a_half_quarter: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[0])
        else $error("half pulse without quarter pulse");

    // status data never shows up together with pulses
    a_read_no_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[10:3] != 8'd0) |-> (m_tdata[1:0] == 2'd0))
        else $error("status data on a pulse item");

    // an accepted read yields a valid result with no pulses and status bit 5 low
    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_READ)
        |=> m_tvalid && (m_tdata[1:0] == 2'd0) && (m_tdata[8] == 1'b0))
        else $error("read item gave a bad result");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind apu_frame_sequencer_top apufs_port_props u_apufs_port_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
